// ----- rtl/core/dcf_pkg.sv -----
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared constants and types for the clock drift filter: field widths,
// filter window size, adjustment limit and the front/back queue word.
// ----------------------------------------------------------------------------
package dcf_pkg;

  // Filter window length in samples; must be a power of two.
  localparam int FILTER_COUNT = 1024;
  localparam int FILTER_LOG2  = $clog2(FILTER_COUNT);
  localparam int FILTER_HALF  = FILTER_COUNT / 2;
  localparam int CNT_W        = $clog2(FILTER_COUNT + 1);

  localparam int ADJ_LIMIT = 1000;

  localparam int PERIOD_W = 30;
  localparam int RAW_W    = 32;
  localparam int FOLD_W   = 30;
  localparam int ADJ_W    = 11;
  localparam int BASE_W   = 64;
  localparam int SUM_W    = 48;

  // Dividend of the modulo unit: raw difference plus half a period.
  localparam int DIV_W  = RAW_W + 1;
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000000);

  typedef struct packed {
    logic [FOLD_W-1:0] folded;
    logic [RAW_W-1:0]  delta;
  } dcf_entry_t;

endpackage

// ----- rtl/core/dc_clock_drift_filter.sv -----
// ----------------------------------------------------------------------------
// dc_clock_drift_filter
// Clock drift filter for a distributed-clock bus master: folds each raw
// clock difference into half a bus cycle, averages over a window and
// tracks a clamped drift adjustment and a 64-bit time base offset.
//
//   channel   handshake              payload
//   input     push / full            diff_raw
//   result    pop / empty            diff_folded, adjust_ns, base_offset,
//                                    started, window_done
//   config    cfg_valid / cfg_ready  cfg_data (cycle period, ns)
//
// The front folds each word with a 33-step bit-serial modulo by the cycle
// period; the filter side runs in parallel behind a two-word queue.
// Synchronous reset clears the sums, window count, adjustment, time base
// and start flag and sets the period to 1 ms.
// A stalled result stalls the filter side only; the front keeps folding
// until the queue fills.
// ----------------------------------------------------------------------------
module dc_clock_drift_filter import dcf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [RAW_W-1:0]    diff_raw,
  output logic                empty,
  input  logic                pop,
  output logic [FOLD_W-1:0]   diff_folded,
  output logic [ADJ_W-1:0]    adjust_ns,
  output logic [BASE_W-1:0]   base_offset,
  output logic                started,
  output logic                window_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  logic [PERIOD_W-1:0] cycle_period;
  logic                fq_push;
  logic                fq_full;
  dcf_entry_t          fq_wdata;
  logic                fq_pop;
  logic                fq_empty;
  dcf_entry_t          fq_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cycle_period <= cfg_data;
    end
  end

  dcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .diff_raw (diff_raw),
    .period   (cycle_period),
    .q_full   (fq_full),
    .q_push   (fq_push),
    .q_data   (fq_wdata)
  );

  dcf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .full    (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fq_rdata),
    .empty   (fq_empty)
  );

  dcf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (fq_empty),
    .q_pop       (fq_pop),
    .q_data      (fq_rdata),
    .pop         (pop),
    .empty       (empty),
    .diff_folded (diff_folded),
    .adjust_ns   (adjust_ns),
    .base_offset (base_offset),
    .started     (started),
    .window_done (window_done)
  );

endmodule

// ----- rtl/core/dcf_front.sv -----
// ----------------------------------------------------------------------------
// dcf_front
// Input side: takes one raw difference, forms the wrapping delta against
// the previous sample and folds the difference into half a period either
// side of zero with a bit-serial restoring modulo unit.
// ----------------------------------------------------------------------------
module dcf_front import dcf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [RAW_W-1:0]    diff_raw,
  input  logic [PERIOD_W-1:0] period,
  input  logic                q_full,
  output logic                q_push,
  output dcf_entry_t          q_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIX, ST_PUSH} state_t;

  state_t                state;
  logic [RAW_W-1:0]      last_raw;
  logic [RAW_W-1:0]      delta;
  logic [PERIOD_W-1:0]   cper;
  logic [PERIOD_W-2:0]   half;
  logic                  neg;
  logic [DIV_W-1:0]      dvd;
  logic [PERIOD_W-1:0]   rem;
  logic [STEP_W-1:0]     step;

  logic [PERIOD_W-1:0]   cper_now;
  logic [DIV_W-1:0]      x_now;
  logic [DIV_W-1:0]      mag_now;
  logic [PERIOD_W:0]     trial;
  logic                  fits;
  logic [PERIOD_W:0]     fold_wide;

  always_comb begin
    cper_now  = (period == '0) ? PERIOD_W'(1) : period;
    x_now     = {diff_raw[RAW_W-1], diff_raw} + DIV_W'(cper_now[PERIOD_W-1:1]);
    mag_now   = x_now[DIV_W-1] ? DIV_W'(-x_now) : x_now;
    trial     = {rem, dvd[DIV_W-1]};
    fits      = trial >= {1'b0, cper};
    fold_wide = {1'b0, rem} - {2'b00, half};
  end

  assign full          = (state != ST_IDLE);
  assign q_push        = (state == ST_PUSH) && !q_full;
  assign q_data.folded = fold_wide[FOLD_W-1:0];
  assign q_data.delta  = delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      last_raw <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (push) begin
            last_raw <= diff_raw;
            delta    <= diff_raw - last_raw;
            cper     <= cper_now;
            half     <= cper_now[PERIOD_W-1:1];
            neg      <= x_now[DIV_W-1];
            dvd      <= mag_now;
            rem      <= '0;
            step     <= '0;
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle, keep only the remainder
          rem  <= fits ? PERIOD_W'(trial - {1'b0, cper}) : trial[PERIOD_W-1:0];
          dvd  <= dvd << 1;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_W - 1)) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          // floor the remainder of a negative dividend
          if (neg && rem != '0) begin
            rem <= cper - rem;
          end
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_period: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_PUSH) |-> (rem < cper))
    else $error("modulo remainder not below period");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> (full && state == ST_DIV))
    else $error("front not busy after accepting a word");

endmodule

// ----- rtl/core/dcf_fifo.sv -----
// ----------------------------------------------------------------------------
// dcf_fifo
// Short queue of folded samples between the front and the back.
// ----------------------------------------------------------------------------
module dcf_fifo import dcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  dcf_entry_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output dcf_entry_t rd_data,
  output logic       empty
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

  dcf_entry_t        slots [QUEUE_DEPTH];
  logic [IDX_W-1:0]  wptr;
  logic [IDX_W-1:0]  rptr;
  logic [CNT_Q-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_Q'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + IDX_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + IDX_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_Q'(1);
        2'b01:   count <= count - CNT_Q'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_Q'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- rtl/core/dcf_back.sv -----
// ----------------------------------------------------------------------------
// dcf_back
// Filter side: accumulates folded differences and deltas, updates the
// clamped adjustment at the end of each window and advances the time base.
// Holds the finished result in an output register until it is popped.
// ----------------------------------------------------------------------------
module dcf_back import dcf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  dcf_entry_t          q_data,
  input  logic                pop,
  output logic                empty,
  output logic [FOLD_W-1:0]   diff_folded,
  output logic [ADJ_W-1:0]    adjust_ns,
  output logic [BASE_W-1:0]   base_offset,
  output logic                started,
  output logic                window_done
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_RND, ST_QUO, ST_ADJ, ST_BASE, ST_OUT
  } state_t;

  localparam int RND_W = SUM_W + 1;
  localparam int ACC_W = RND_W + 1;
  localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(ADJ_LIMIT);
  localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;
  localparam logic signed [SUM_W-1:0] FC_POS = SUM_W'(FILTER_COUNT);
  localparam logic signed [SUM_W-1:0] FC_NEG = -FC_POS;

  state_t                   state;
  dcf_entry_t               cur;
  logic                     started_flag;
  logic signed [SUM_W-1:0]  diff_sum;
  logic signed [SUM_W-1:0]  delta_sum;
  logic [CNT_W-1:0]         wcount;
  logic [ADJ_W-1:0]         adj_value;
  logic [BASE_W-1:0]        time_base;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  quo;
  logic [1:0]               sdiff;
  logic                     done;
  logic                     out_valid;
  logic                     out_load;

  logic signed [RND_W-1:0]  biased;
  logic signed [ACC_W-1:0]  acc;
  logic [ADJ_W:0]           fsgn;
  logic [ADJ_W:0]           tb_step;

  always_comb begin
    biased  = rnd + (rnd[RND_W-1] ? RND_W'(FILTER_COUNT - 1) : RND_W'(0));
    acc     = {{(ACC_W-ADJ_W){adj_value[ADJ_W-1]}}, adj_value}
            + {quo[RND_W-1], quo}
            + {{(ACC_W-2){sdiff[1]}}, sdiff};
    fsgn    = (cur.folded == '0) ? '0 :
              (cur.folded[FOLD_W-1] ? '1 : (ADJ_W+1)'(1));
    tb_step = {adj_value[ADJ_W-1], adj_value} + fsgn;
  end

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign out_load = (state == ST_OUT) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      started_flag <= 1'b0;
      diff_sum     <= '0;
      delta_sum    <= '0;
      wcount       <= '0;
      adj_value    <= '0;
      time_base    <= '0;
      done         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur   <= q_data;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          done <= 1'b0;
          if (!started_flag) begin
            // arm on the first nonzero folded difference
            started_flag <= (cur.folded != '0);
            state        <= ST_OUT;
          end else begin
            diff_sum  <= diff_sum
                       + {{(SUM_W-FOLD_W){cur.folded[FOLD_W-1]}}, cur.folded};
            delta_sum <= delta_sum
                       + {{(SUM_W-RAW_W){cur.delta[RAW_W-1]}}, cur.delta};
            if (wcount == CNT_W'(FILTER_COUNT - 1)) begin
              state <= ST_RND;
            end else begin
              wcount <= wcount + CNT_W'(1);
              state  <= ST_BASE;
            end
          end
        end
        ST_RND: begin
          rnd <= {delta_sum[SUM_W-1], delta_sum} + RND_W'(FILTER_HALF);
          if (diff_sum >= FC_POS) begin
            sdiff <= 2'b01;
          end else if (diff_sum <= FC_NEG) begin
            sdiff <= 2'b11;
          end else begin
            sdiff <= 2'b00;
          end
          state <= ST_QUO;
        end
        ST_QUO: begin
          // truncate toward zero
          quo   <= biased >>> FILTER_LOG2;
          state <= ST_ADJ;
        end
        ST_ADJ: begin
          if (acc > LIM_HI) begin
            adj_value <= ADJ_W'(ADJ_LIMIT);
          end else if (acc < LIM_LO) begin
            adj_value <= ADJ_W'(-ADJ_LIMIT);
          end else begin
            adj_value <= acc[ADJ_W-1:0];
          end
          diff_sum  <= '0;
          delta_sum <= '0;
          wcount    <= '0;
          done      <= 1'b1;
          state     <= ST_BASE;
        end
        ST_BASE: begin
          time_base <= time_base + {{(BASE_W-ADJ_W-1){tb_step[ADJ_W]}}, tb_step};
          state     <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            diff_folded <= cur.folded;
            adjust_ns   <= adj_value;
            base_offset <= time_base;
            started     <= started_flag;
            window_done <= done;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    wcount <= CNT_W'(FILTER_COUNT - 1))
    else $error("window count past filter length");

  a_adjust_clamped: assert property (@(posedge clk) disable iff (rst)
    ($signed(adj_value) <= $signed(ADJ_W'(ADJ_LIMIT)))
    && ($signed(adj_value) >= $signed(ADJ_W'(-ADJ_LIMIT))))
    else $error("adjustment outside clamp range");

  a_done_needs_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_done) |-> started)
    else $error("window closed before start");

endmodule
